[rtl/rtc_pkg.sv]
`timescale 1ns / 1ps

package rtc_pkg;

    // Radio modes
    localparam logic [2:0] MODE_SLEEP     = 3'd0;
    localparam logic [2:0] MODE_IDLE      = 3'd1;
    localparam logic [2:0] MODE_LISTEN    = 3'd2;
    localparam logic [2:0] MODE_RECEIVING = 3'd3;
    localparam logic [2:0] MODE_TRANSMIT  = 3'd4;
    localparam int         MODE_COUNT     = 5;

    // Event codes
    localparam logic [3:0] REQ_TICK     = 4'd0;
    localparam logic [3:0] REQ_TX_START = 4'd1;
    localparam logic [3:0] REQ_TX_END   = 4'd2;
    localparam logic [3:0] REQ_CS       = 4'd3;
    localparam logic [3:0] REQ_RX_END   = 4'd4;
    localparam logic [3:0] REQ_SLEEP    = 4'd5;
    localparam logic [3:0] REQ_WAKEUP   = 4'd6;
    localparam logic [3:0] REQ_LISTEN   = 4'd7;
    localparam logic [3:0] REQ_IDLE     = 4'd8;

    // Result status codes
    localparam logic [3:0] ST_DONE       = 4'd0;
    localparam logic [3:0] ST_IGNORED    = 4'd1;
    localparam logic [3:0] ST_ASLEEP     = 4'd2;
    localparam logic [3:0] ST_TXBUSY     = 4'd3;
    localparam logic [3:0] ST_NOTRX      = 4'd4;
    localparam logic [3:0] ST_WRONG      = 4'd5;
    localparam logic [3:0] ST_DEAD       = 4'd6;
    localparam logic [3:0] ST_ERRDROP    = 4'd7;
    localparam logic [3:0] ST_INVALID    = 4'd8;
    localparam logic [3:0] ST_DELIVERED  = 4'd9;
    localparam logic [3:0] ST_TXMISMATCH = 4'd10;

    // Configuration register indexes
    localparam int         CFG_INDEX_BITS  = 2;
    localparam int         CFG_DATA_BITS   = 16;
    localparam logic [1:0] CFG_CHANNEL     = 2'd0;
    localparam logic [1:0] CFG_SENSITIVITY = 2'd1;
    localparam logic [1:0] CFG_SYMBOL      = 2'd2;
    localparam logic [1:0] CFG_MODULATION  = 2'd3;

    // Power levels in quarter dBm
    localparam logic signed [9:0]  RSSI_FLOOR = -10'sd512;
    localparam logic signed [9:0]  SENS_CEIL  = -10'sd340;
    localparam logic signed [10:0] MARGIN_QDB = 11'sd20;

    // Reset values of the configuration registers
    localparam logic [4:0]  CHANNEL_RST = 5'd0;
    localparam logic [15:0] SYMBOL_RST  = 16'd16000;
    localparam logic [3:0]  MODUL_RST   = 4'd0;

    typedef struct packed {
        logic [4:0]        radio_channel;
        logic signed [9:0] sensitivity_qdbm;
        logic [15:0]       symbol_period_ns;
        logic [3:0]        modulation_id;
    } cfg_t;

    // Event word minus the frame id
    typedef struct packed {
        logic [3:0]        req_type;
        logic signed [9:0] frame_rssi_qdbm;
        logic [4:0]        frame_channel;
        logic [15:0]       frame_symbol_period_ns;
        logic [3:0]        frame_modulation;
        logic              node_alive;
        logic              error_drop;
    } item_t;

endpackage

[rtl/rtc_cfg_regs.sv]
`timescale 1ns / 1ps

module rtc_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rtc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [rtc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output rtc_pkg::cfg_t                        cfg
);

    rtc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register file, always ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radio_channel    <= rtc_pkg::CHANNEL_RST;
            cfg_reg.sensitivity_qdbm <= rtc_pkg::SENS_CEIL;
            cfg_reg.symbol_period_ns <= rtc_pkg::SYMBOL_RST;
            cfg_reg.modulation_id    <= rtc_pkg::MODUL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rtc_pkg::CFG_CHANNEL:     cfg_reg.radio_channel    <= cfg_data[4:0];
                rtc_pkg::CFG_SENSITIVITY: cfg_reg.sensitivity_qdbm <= $signed(cfg_data[9:0]);
                rtc_pkg::CFG_SYMBOL:      cfg_reg.symbol_period_ns <= cfg_data[15:0];
                rtc_pkg::CFG_MODULATION:  cfg_reg.modulation_id    <= cfg_data[3:0];
                default:                  cfg_reg.radio_channel    <= cfg_reg.radio_channel;
            endcase
        end
    end

endmodule

[rtl/rtc_in_stage.sv]
`timescale 1ns / 1ps

module rtc_in_stage
#(
    parameter int FRAME_ID_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [FRAME_ID_BITS-1:0] frame_id,
    input  rtc_pkg::item_t           item,
    input  logic                     out_free,
    output logic                     s1_valid,
    output logic [FRAME_ID_BITS-1:0] s1_frame_id,
    output rtc_pkg::item_t           s1_item
);

    logic                     s1_valid_reg;
    logic [FRAME_ID_BITS-1:0] s1_id_reg;
    rtc_pkg::item_t           s1_item_reg;

    // Hold the word while the result side cannot take it
    assign in_stall    = s1_valid_reg && !out_free;
    assign s1_valid    = s1_valid_reg;
    assign s1_frame_id = s1_id_reg;
    assign s1_item     = s1_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_id_reg   <= frame_id;
            s1_item_reg <= item;
        end
    end

endmodule

[rtl/rtc_ctrl.sv]
`timescale 1ns / 1ps

module rtc_ctrl
#(
    parameter int FRAME_ID_BITS   = 16,
    parameter int TICK_COUNT_BITS = 48
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  rtc_pkg::cfg_t            cfg,
    input  logic                     s1_valid,
    input  logic [FRAME_ID_BITS-1:0] s1_frame_id,
    input  rtc_pkg::item_t           s1_item,
    output logic                     out_free,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [3:0]               status,
    output logic [2:0]               radio_state,
    output logic signed [9:0]        best_rssi_qdbm,
    output logic                     deliver
);

    // Radio state
    logic [2:0]               mode_reg, mode_next;
    logic                     tx_active_reg, tx_active_next;
    logic [FRAME_ID_BITS-1:0] tx_frame_reg, tx_frame_next;
    logic                     rx_active_reg, rx_active_next;
    logic [FRAME_ID_BITS-1:0] rx_frame_reg, rx_frame_next;
    logic signed [9:0]        best_rssi_reg, best_rssi_next;
    logic                     rx_spoiled_reg, rx_spoiled_next;
    logic [TICK_COUNT_BITS-1:0] ticks_reg [rtc_pkg::MODE_COUNT];

    // Result register
    logic                     out_valid_reg;
    logic [3:0]               status_reg, status_next;
    logic                     deliver_reg, deliver_next;

    logic                     process;
    logic signed [9:0]        sens_eff;
    logic signed [10:0]       threshold;
    logic                     head_ok;

    assign out_free       = !out_valid_reg || !out_stall;
    assign process        = s1_valid && out_free;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign radio_state    = mode_reg;
    assign best_rssi_qdbm = best_rssi_reg;
    assign deliver        = deliver_reg;

    // Frame head acceptance: power over clamped sensitivity minus 5 dB, PHY match
    always_comb
    begin
        sens_eff  = (cfg.sensitivity_qdbm > rtc_pkg::SENS_CEIL) ? rtc_pkg::SENS_CEIL
                                                                 : cfg.sensitivity_qdbm;
        threshold = {sens_eff[9], sens_eff} - rtc_pkg::MARGIN_QDB;
        head_ok   = !($signed({s1_item.frame_rssi_qdbm[9], s1_item.frame_rssi_qdbm})
                      < threshold)
                    && (s1_item.frame_channel == cfg.radio_channel)
                    && (s1_item.frame_symbol_period_ns == cfg.symbol_period_ns)
                    && (s1_item.frame_modulation == cfg.modulation_id);
    end

    // Event decode and next state
    always_comb
    begin
        mode_next       = mode_reg;
        tx_active_next  = tx_active_reg;
        tx_frame_next   = tx_frame_reg;
        rx_active_next  = rx_active_reg;
        rx_frame_next   = rx_frame_reg;
        best_rssi_next  = best_rssi_reg;
        rx_spoiled_next = rx_spoiled_reg;
        status_next     = rtc_pkg::ST_DONE;
        deliver_next    = 1'b0;

        unique case (s1_item.req_type)
            rtc_pkg::REQ_TICK:
            begin
                status_next = rtc_pkg::ST_DONE;
            end
            rtc_pkg::REQ_TX_START:
            begin
                if (mode_reg == rtc_pkg::MODE_SLEEP)
                begin
                    status_next = rtc_pkg::ST_ASLEEP;
                end
                else
                begin
                    // carrier reset clears rx first, so no spoil
                    rx_active_next = 1'b0;
                    best_rssi_next = rtc_pkg::RSSI_FLOOR;
                    tx_active_next = 1'b1;
                    tx_frame_next  = s1_frame_id;
                    mode_next      = rtc_pkg::MODE_TRANSMIT;
                end
            end
            rtc_pkg::REQ_TX_END:
            begin
                if (!s1_item.node_alive)
                begin
                    status_next = rtc_pkg::ST_DEAD;
                end
                else if (tx_active_reg && (tx_frame_reg == s1_frame_id))
                begin
                    tx_active_next = 1'b0;
                    mode_next      = rtc_pkg::MODE_IDLE;
                    if (mode_reg != rtc_pkg::MODE_IDLE && rx_active_reg)
                    begin
                        rx_spoiled_next = 1'b1;
                    end
                end
                else
                begin
                    status_next = rtc_pkg::ST_TXMISMATCH;
                end
            end
            rtc_pkg::REQ_CS:
            begin
                priority if (mode_reg == rtc_pkg::MODE_SLEEP)
                    status_next = rtc_pkg::ST_ASLEEP;
                else if (tx_active_reg)
                    status_next = rtc_pkg::ST_TXBUSY;
                else if (mode_reg != rtc_pkg::MODE_LISTEN
                         && mode_reg != rtc_pkg::MODE_RECEIVING)
                    status_next = rtc_pkg::ST_NOTRX;
                else if (!head_ok)
                    status_next = rtc_pkg::ST_WRONG;
                else if (s1_item.frame_rssi_qdbm > best_rssi_reg)
                begin
                    // strongest head captures the receiver
                    best_rssi_next = s1_item.frame_rssi_qdbm;
                    mode_next      = rtc_pkg::MODE_RECEIVING;
                    rx_active_next = 1'b1;
                    rx_frame_next  = s1_frame_id;
                    if (mode_reg != rtc_pkg::MODE_RECEIVING && rx_active_reg)
                    begin
                        rx_spoiled_next = 1'b1;
                    end
                end
                else
                    status_next = rtc_pkg::ST_IGNORED;
            end
            rtc_pkg::REQ_RX_END:
            begin
                priority if (mode_reg == rtc_pkg::MODE_SLEEP)
                    status_next = rtc_pkg::ST_ASLEEP;
                else if (tx_active_reg)
                    status_next = rtc_pkg::ST_TXBUSY;
                else if (mode_reg != rtc_pkg::MODE_RECEIVING)
                begin
                    rx_spoiled_next = 1'b0;
                    rx_active_next  = 1'b0;
                    status_next     = rtc_pkg::ST_NOTRX;
                end
                else if (!(rx_active_reg && (rx_frame_reg == s1_frame_id)))
                    status_next = rtc_pkg::ST_WRONG;
                else
                begin
                    // release the held frame
                    rx_active_next = 1'b0;
                    best_rssi_next = rtc_pkg::RSSI_FLOOR;
                    mode_next      = rtc_pkg::MODE_LISTEN;
                    priority if (!s1_item.node_alive)
                        status_next = rtc_pkg::ST_DEAD;
                    else if (s1_item.error_drop)
                        status_next = rtc_pkg::ST_ERRDROP;
                    else if (rx_spoiled_reg)
                    begin
                        rx_spoiled_next = 1'b0;
                        status_next     = rtc_pkg::ST_INVALID;
                    end
                    else
                    begin
                        mode_next       = rtc_pkg::MODE_IDLE;
                        rx_spoiled_next = 1'b0;
                        deliver_next    = 1'b1;
                        status_next     = rtc_pkg::ST_DELIVERED;
                    end
                end
            end
            rtc_pkg::REQ_SLEEP:
            begin
                tx_active_next = 1'b0;
                rx_active_next = 1'b0;
                best_rssi_next = rtc_pkg::RSSI_FLOOR;
                mode_next      = rtc_pkg::MODE_SLEEP;
            end
            rtc_pkg::REQ_WAKEUP:
            begin
                tx_active_next = 1'b0;
                rx_active_next = 1'b0;
                best_rssi_next = rtc_pkg::RSSI_FLOOR;
                mode_next      = rtc_pkg::MODE_IDLE;
            end
            rtc_pkg::REQ_LISTEN:
            begin
                mode_next = rtc_pkg::MODE_LISTEN;
                if (mode_reg != rtc_pkg::MODE_LISTEN && rx_active_reg)
                begin
                    rx_spoiled_next = 1'b1;
                end
            end
            rtc_pkg::REQ_IDLE:
            begin
                mode_next = rtc_pkg::MODE_IDLE;
                if (mode_reg != rtc_pkg::MODE_IDLE && rx_active_reg)
                begin
                    rx_spoiled_next = 1'b1;
                end
            end
            default:
            begin
                status_next = rtc_pkg::ST_IGNORED;
            end
        endcase
    end

    // Control state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= rtc_pkg::MODE_SLEEP;
            tx_active_reg  <= 1'b0;
            tx_frame_reg   <= '0;
            rx_active_reg  <= 1'b0;
            rx_frame_reg   <= '0;
            best_rssi_reg  <= rtc_pkg::RSSI_FLOOR;
            rx_spoiled_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= s1_valid;
            end
            if (process)
            begin
                mode_reg       <= mode_next;
                tx_active_reg  <= tx_active_next;
                tx_frame_reg   <= tx_frame_next;
                rx_active_reg  <= rx_active_next;
                rx_frame_reg   <= rx_frame_next;
                best_rssi_reg  <= best_rssi_next;
                rx_spoiled_reg <= rx_spoiled_next;
            end
        end
    end

    // Per-mode time counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rtc_pkg::MODE_COUNT; i++)
            begin
                ticks_reg[i] <= '0;
            end
        end
        else if (process && (s1_item.req_type == rtc_pkg::REQ_TICK)
                 && (mode_reg < 3'(rtc_pkg::MODE_COUNT)))
        begin
            ticks_reg[mode_reg] <= ticks_reg[mode_reg] + 1'b1;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            status_reg  <= status_next;
            deliver_reg <= deliver_next;
        end
    end

`ifndef SYNTHESIS
    a_deliver_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && deliver_reg) |->
            (status_reg == rtc_pkg::ST_DELIVERED && mode_reg == rtc_pkg::MODE_IDLE))
        else $error("deliver without delivered status in idle");

    a_rx_tx_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rx_active_reg |-> !tx_active_reg)
        else $error("reception held while transmitting");

    a_sleep_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (process && s1_item.req_type == rtc_pkg::REQ_SLEEP) |=>
            (mode_reg == rtc_pkg::MODE_SLEEP && !rx_active_reg && !tx_active_reg
             && best_rssi_reg == rtc_pkg::RSSI_FLOOR))
        else $error("sleep event left carrier state");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> ($stable(mode_reg) && $stable(best_rssi_reg)))
        else $error("state advanced while result stalled");
`endif

endmodule

[rtl/radio_transceiver_state_control.sv]
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// in        in_valid / in_stall     req_type, frame_id, frame_*, node_alive, error_drop
// out       out_valid / out_stall   status, radio_state, best_rssi_qdbm, deliver
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One event per cycle while out_stall is low; each event goes through the input register,
// then is decoded into the result register and radio state.
// Reset: asynchronous, active low; radio asleep, counters and captures cleared.
// out_stall freezes the result register; the input register then fills and in_stall
// rises. cfg_ready is always high.

module radio_transceiver_state_control
#(
    parameter int FRAME_ID_BITS   = 16,
    parameter int TICK_COUNT_BITS = 48
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rtc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [rtc_pkg::CFG_DATA_BITS-1:0]    cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [3:0]                           req_type,
    input  logic [FRAME_ID_BITS-1:0]             frame_id,
    input  logic signed [9:0]                    frame_rssi_qdbm,
    input  logic [4:0]                           frame_channel,
    input  logic [15:0]                          frame_symbol_period_ns,
    input  logic [3:0]                           frame_modulation,
    input  logic                                 node_alive,
    input  logic                                 error_drop,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [3:0]                           status,
    output logic [2:0]                           radio_state,
    output logic signed [9:0]                    best_rssi_qdbm,
    output logic                                 deliver
);

    rtc_pkg::cfg_t            cfg;
    rtc_pkg::item_t           item;
    rtc_pkg::item_t           s1_item;
    logic                     s1_valid;
    logic [FRAME_ID_BITS-1:0] s1_frame_id;
    logic                     out_free;

    // Pack the input word
    always_comb
    begin
        item.req_type               = req_type;
        item.frame_rssi_qdbm        = frame_rssi_qdbm;
        item.frame_channel          = frame_channel;
        item.frame_symbol_period_ns = frame_symbol_period_ns;
        item.frame_modulation       = frame_modulation;
        item.node_alive             = node_alive;
        item.error_drop             = error_drop;
    end

    rtc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtc_in_stage
    #(
        .FRAME_ID_BITS (FRAME_ID_BITS)
    )
    u_in
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .frame_id    (frame_id),
        .item        (item),
        .out_free    (out_free),
        .s1_valid    (s1_valid),
        .s1_frame_id (s1_frame_id),
        .s1_item     (s1_item)
    );

    rtc_ctrl
    #(
        .FRAME_ID_BITS   (FRAME_ID_BITS),
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    )
    u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .s1_valid       (s1_valid),
        .s1_frame_id    (s1_frame_id),
        .s1_item        (s1_item),
        .out_free       (out_free),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .radio_state    (radio_state),
        .best_rssi_qdbm (best_rssi_qdbm),
        .deliver        (deliver)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int          TICK_BITS     = 48;
    localparam int          PHASE_EVENTS  = 360;
    localparam int          PHASE_COUNT   = 5;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          HOLD_CYCLES   = 80;
    localparam logic [3:0]  REQ_UNDEFINED = 4'd15;

    typedef struct packed {
        logic [3:0]        req;
        logic [15:0]       id;
        logic signed [9:0] rssi;
        logic [4:0]        chan;
        logic [15:0]       sym;
        logic [3:0]        modu;
        logic              alive;
        logic              drop;
    } radio_event_t;

    typedef struct packed {
        logic [3:0]        status;
        logic [2:0]        state;
        logic signed [9:0] rssi;
        logic              deliver;
    } radio_result_t;

    typedef struct packed {
        radio_event_t  ev;
        logic          typed;
        radio_result_t res;
    } script_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [rtc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [rtc_pkg::CFG_DATA_BITS-1:0]  cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [3:0]               req_type;
    logic [15:0]              frame_id;
    logic signed [9:0]        frame_rssi_qdbm;
    logic [4:0]               frame_channel;
    logic [15:0]              frame_symbol_period_ns;
    logic [3:0]               frame_modulation;
    logic                     node_alive;
    logic                     error_drop;
    logic                     out_valid;
    logic                     out_stall;
    logic [3:0]               status;
    logic [2:0]               radio_state;
    logic signed [9:0]        best_rssi_qdbm;
    logic                     deliver;

    // Radio model: settings and state as the block should hold them
    logic [4:0]               own_chan;
    logic signed [9:0]        own_sens;
    logic [15:0]              own_sym;
    logic [3:0]               own_modu;
    logic [2:0]               radio_mode;
    logic                     tx_busy;
    logic [15:0]              tx_id;
    logic                     rx_held;
    logic [15:0]              rx_id;
    logic signed [9:0]        best_rssi;
    logic                     rx_spoiled;
    logic [TICK_BITS-1:0]     mode_ticks [rtc_pkg::MODE_COUNT];

    radio_result_t            pending_results [$];
    script_row_t              script [$];
    int                       errors      = 0;
    int                       burst_left  = 0;
    int                       steady_left = 0;
    bit                       hold_go     = 1'b0;

    radio_transceiver_state_control dut
    (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .in_valid               (in_valid),
        .in_stall               (in_stall),
        .req_type               (req_type),
        .frame_id               (frame_id),
        .frame_rssi_qdbm        (frame_rssi_qdbm),
        .frame_channel          (frame_channel),
        .frame_symbol_period_ns (frame_symbol_period_ns),
        .frame_modulation       (frame_modulation),
        .node_alive             (node_alive),
        .error_drop             (error_drop),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .status                 (status),
        .radio_state            (radio_state),
        .best_rssi_qdbm         (best_rssi_qdbm),
        .deliver                (deliver)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mode change spoils a held reception
    task automatic switch_mode(input logic [2:0] next);
        if (radio_mode != next)
        begin
            if (rx_held)
                rx_spoiled = 1'b1;
            radio_mode = next;
        end
    endtask

    task automatic drop_carrier();
        tx_busy   = 1'b0;
        rx_held   = 1'b0;
        best_rssi = rtc_pkg::RSSI_FLOOR;
        switch_mode(rtc_pkg::MODE_IDLE);
    endtask

    // One event in, one result word out
    task automatic advance_radio(input radio_event_t ev, output radio_result_t res);
        int sens_floor;
        res         = '0;
        res.status  = rtc_pkg::ST_DONE;
        case (ev.req)
            rtc_pkg::REQ_TICK:
                mode_ticks[radio_mode] = mode_ticks[radio_mode] + 1'b1;
            rtc_pkg::REQ_TX_START:
                if (radio_mode == rtc_pkg::MODE_SLEEP)
                    res.status = rtc_pkg::ST_ASLEEP;
                else
                begin
                    drop_carrier();
                    tx_busy = 1'b1;
                    tx_id   = ev.id;
                    switch_mode(rtc_pkg::MODE_TRANSMIT);
                end
            rtc_pkg::REQ_TX_END:
                if (!ev.alive)
                    res.status = rtc_pkg::ST_DEAD;
                else if (tx_busy && tx_id == ev.id)
                begin
                    tx_busy = 1'b0;
                    switch_mode(rtc_pkg::MODE_IDLE);
                end
                else
                    res.status = rtc_pkg::ST_TXMISMATCH;
            rtc_pkg::REQ_CS:
            begin
                sens_floor = own_sens;
                if (sens_floor > rtc_pkg::SENS_CEIL)
                    sens_floor = rtc_pkg::SENS_CEIL;
                sens_floor = sens_floor - rtc_pkg::MARGIN_QDB;
                if (radio_mode == rtc_pkg::MODE_SLEEP)
                    res.status = rtc_pkg::ST_ASLEEP;
                else if (tx_busy)
                    res.status = rtc_pkg::ST_TXBUSY;
                else if (radio_mode != rtc_pkg::MODE_LISTEN
                         && radio_mode != rtc_pkg::MODE_RECEIVING)
                    res.status = rtc_pkg::ST_NOTRX;
                else if (int'(ev.rssi) < sens_floor || ev.chan != own_chan
                         || ev.sym != own_sym || ev.modu != own_modu)
                    res.status = rtc_pkg::ST_WRONG;
                else if (ev.rssi > best_rssi)
                begin
                    best_rssi = ev.rssi;
                    switch_mode(rtc_pkg::MODE_RECEIVING);
                    rx_held = 1'b1;
                    rx_id   = ev.id;
                end
                else
                    res.status = rtc_pkg::ST_IGNORED;
            end
            rtc_pkg::REQ_RX_END:
                if (radio_mode == rtc_pkg::MODE_SLEEP)
                    res.status = rtc_pkg::ST_ASLEEP;
                else if (tx_busy)
                    res.status = rtc_pkg::ST_TXBUSY;
                else if (radio_mode != rtc_pkg::MODE_RECEIVING)
                begin
                    rx_spoiled = 1'b0;
                    rx_held    = 1'b0;
                    res.status = rtc_pkg::ST_NOTRX;
                end
                else if (!(rx_held && rx_id == ev.id))
                    res.status = rtc_pkg::ST_WRONG;
                else
                begin
                    // release the frame, then decide its fate
                    rx_held   = 1'b0;
                    best_rssi = rtc_pkg::RSSI_FLOOR;
                    switch_mode(rtc_pkg::MODE_LISTEN);
                    if (!ev.alive)
                        res.status = rtc_pkg::ST_DEAD;
                    else if (ev.drop)
                        res.status = rtc_pkg::ST_ERRDROP;
                    else if (rx_spoiled)
                    begin
                        rx_spoiled = 1'b0;
                        res.status = rtc_pkg::ST_INVALID;
                    end
                    else
                    begin
                        switch_mode(rtc_pkg::MODE_IDLE);
                        rx_spoiled  = 1'b0;
                        res.deliver = 1'b1;
                        res.status  = rtc_pkg::ST_DELIVERED;
                    end
                end
            rtc_pkg::REQ_SLEEP:
            begin
                drop_carrier();
                switch_mode(rtc_pkg::MODE_SLEEP);
            end
            rtc_pkg::REQ_WAKEUP:
                drop_carrier();
            rtc_pkg::REQ_LISTEN:
                switch_mode(rtc_pkg::MODE_LISTEN);
            rtc_pkg::REQ_IDLE:
                switch_mode(rtc_pkg::MODE_IDLE);
            default:
                res.status = rtc_pkg::ST_IGNORED;
        endcase
        res.state = radio_mode;
        res.rssi  = best_rssi;
    endtask

    // Directed table helpers
    task automatic row(input logic [3:0] req, input logic [15:0] id, input int rssi,
                       input logic [4:0] chan, input logic [15:0] sym, input logic [3:0] modu,
                       input logic alive, input logic drop);
        script_row_t r;
        r    = '0;
        r.ev = '{req, id, 10'(rssi), chan, sym, modu, alive, drop};
        script.push_back(r);
    endtask

    task automatic typed_as(input logic [3:0] st, input logic [2:0] md, input int best,
                            input logic dlv);
        script_row_t r;
        r       = script.pop_back();
        r.typed = 1'b1;
        r.res   = '{st, md, 10'(best), dlv};
        script.push_back(r);
    endtask

    // Sender: bursts with random gaps, or back to back while steady_left runs
    task automatic send_event(input radio_event_t ev, input logic typed,
                              input radio_result_t typed_res);
        radio_result_t predicted;
        int            idle_cycles;
        if (steady_left > 0)
            steady_left--;
        else if (burst_left == 0)
        begin
            burst_left  = $urandom_range(1, 24);
            idle_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (idle_cycles > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (idle_cycles - 1) @(negedge clk);
            end
        end
        else
            burst_left--;
        @(negedge clk);
        in_valid               = 1'b1;
        req_type               = ev.req;
        frame_id               = ev.id;
        frame_rssi_qdbm        = ev.rssi;
        frame_channel          = ev.chan;
        frame_symbol_period_ns = ev.sym;
        frame_modulation       = ev.modu;
        node_alive             = ev.alive;
        error_drop             = ev.drop;
        do @(posedge clk); while (in_stall);
        advance_radio(ev, predicted);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Random event, steered by the model so most frames run to their end
    task automatic draw_event(output radio_event_t ev);
        int pick;
        int floor_q;
        int mag;
        pick     = $urandom_range(0, 99);
        ev.id    = 16'($urandom);
        ev.chan  = ($urandom_range(0, 6) != 0) ? own_chan : 5'($urandom_range(0, 26));
        ev.sym   = ($urandom_range(0, 6) != 0) ? own_sym : 16'($urandom);
        ev.modu  = ($urandom_range(0, 6) != 0) ? own_modu : 4'($urandom_range(0, 15));
        ev.alive = ($urandom_range(0, 9) != 0);
        ev.drop  = ($urandom_range(0, 6) == 0);
        floor_q  = own_sens;
        if (floor_q > rtc_pkg::SENS_CEIL)
            floor_q = rtc_pkg::SENS_CEIL;
        floor_q = floor_q - rtc_pkg::MARGIN_QDB;
        if (floor_q < rtc_pkg::RSSI_FLOOR)
            floor_q = rtc_pkg::RSSI_FLOOR;
        mag     = ($urandom_range(0, 3) != 0) ? $urandom_range(0, -floor_q)
                                               : $urandom_range(0, 512);
        ev.rssi = 10'(-mag);
        if (pick < 7)
            ev.req = rtc_pkg::REQ_TICK;
        else if (pick < 15)
            ev.req = rtc_pkg::REQ_TX_START;
        else if (pick < 25)
        begin
            ev.req = rtc_pkg::REQ_TX_END;
            if ($urandom_range(0, 4) != 0)
                ev.id = tx_id;
        end
        else if (pick < 55)
            ev.req = rtc_pkg::REQ_CS;
        else if (pick < 70)
        begin
            ev.req = rtc_pkg::REQ_RX_END;
            if ($urandom_range(0, 4) != 0)
                ev.id = rx_id;
        end
        else if (pick < 73)
            ev.req = rtc_pkg::REQ_SLEEP;
        else if (pick < 81)
            ev.req = rtc_pkg::REQ_WAKEUP;
        else if (pick < 93)
            ev.req = rtc_pkg::REQ_LISTEN;
        else if (pick < 97)
            ev.req = rtc_pkg::REQ_IDLE;
        else
            ev.req = 4'($urandom_range(int'(rtc_pkg::REQ_IDLE) + 1, int'(REQ_UNDEFINED)));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            rtc_pkg::CFG_CHANNEL:     own_chan = data[4:0];
            rtc_pkg::CFG_SENSITIVITY: own_sens = data[9:0];
            rtc_pkg::CFG_SYMBOL:      own_sym  = data;
            rtc_pkg::CFG_MODULATION:  own_modu = data[3:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [4:0] ch, input int sens,
                                  input logic [15:0] sym, input logic [3:0] modu);
        write_reg(rtc_pkg::CFG_CHANNEL, 16'(ch));
        write_reg(rtc_pkg::CFG_SENSITIVITY, 16'(sens));
        write_reg(rtc_pkg::CFG_SYMBOL, sym);
        write_reg(rtc_pkg::CFG_MODULATION, 16'(modu));
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drain: stop offering, wait for every result word, then let the pipe empty
    task automatic settle(input int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    // Receiver: stall pattern rotates through four patterns, plus one long hold
    initial
    begin
        int cyc;
        int hold_left;
        bit hold_done;
        cyc       = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall = 1'b1;
            end
            else
                case ((cyc / 173) % 4)
                    0:       out_stall = 1'b0;
                    1:       out_stall = ($urandom_range(0, 3) == 0);
                    2:       out_stall = ($urandom_range(0, 3) != 0);
                    default: out_stall = (cyc % 3 == 0);
                endcase
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        radio_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no event pending: status %0d", status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (radio_state !== want.state)
                begin
                    $error("radio_state: expected %0d, got %0d", want.state, radio_state);
                    errors++;
                end
                if (best_rssi_qdbm !== want.rssi)
                begin
                    $error("best_rssi_qdbm: expected %0d, got %0d", want.rssi, best_rssi_qdbm);
                    errors++;
                end
                if (deliver !== want.deliver)
                begin
                    $error("deliver: expected %0d, got %0d", want.deliver, deliver);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int           n;
        radio_event_t ev;

        rst_n                  = 1'b0;
        cfg_valid              = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        in_valid               = 1'b0;
        req_type               = rtc_pkg::REQ_TICK;
        frame_id               = '0;
        frame_rssi_qdbm        = '0;
        frame_channel          = '0;
        frame_symbol_period_ns = '0;
        frame_modulation       = '0;
        node_alive             = 1'b0;
        error_drop             = 1'b0;

        own_chan   = rtc_pkg::CHANNEL_RST;
        own_sens   = rtc_pkg::SENS_CEIL;
        own_sym    = rtc_pkg::SYMBOL_RST;
        own_modu   = rtc_pkg::MODUL_RST;
        radio_mode = rtc_pkg::MODE_SLEEP;
        tx_busy    = 1'b0;
        tx_id      = '0;
        rx_held    = 1'b0;
        rx_id      = '0;
        best_rssi  = rtc_pkg::RSSI_FLOOR;
        rx_spoiled = 1'b0;
        foreach (mode_ticks[m])
            mode_ticks[m] = '0;

        // Directed: asleep, transmit path, threshold edge, capture, frame endings
        row(rtc_pkg::REQ_TICK, 16'h0000, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_DONE, rtc_pkg::MODE_SLEEP, -512, 0);
        row(rtc_pkg::REQ_CS, 16'h0001, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_ASLEEP, rtc_pkg::MODE_SLEEP, -512, 0);
        row(rtc_pkg::REQ_TX_START, 16'h0002, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_ASLEEP, rtc_pkg::MODE_SLEEP, -512, 0);
        row(rtc_pkg::REQ_TX_END, 16'h0002, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 0, 0);
        typed_as(rtc_pkg::ST_DEAD, rtc_pkg::MODE_SLEEP, -512, 0);
        row(rtc_pkg::REQ_TX_END, 16'h0005, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_TXMISMATCH, rtc_pkg::MODE_SLEEP, -512, 0);
        row(REQ_UNDEFINED, 16'hFFFF, -512, 5'd26, 16'hFFFF, 4'd15, 0, 1);
        typed_as(rtc_pkg::ST_IGNORED, rtc_pkg::MODE_SLEEP, -512, 0);
        row(rtc_pkg::REQ_WAKEUP, 16'h0000, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_DONE, rtc_pkg::MODE_IDLE, -512, 0);
        row(rtc_pkg::REQ_TX_START, 16'hFFFF, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_DONE, rtc_pkg::MODE_TRANSMIT, -512, 0);
        row(rtc_pkg::REQ_CS, 16'h0003, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_TXBUSY, rtc_pkg::MODE_TRANSMIT, -512, 0);
        row(rtc_pkg::REQ_TX_END, 16'hFFFF, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_DONE, rtc_pkg::MODE_IDLE, -512, 0);
        row(rtc_pkg::REQ_LISTEN, 16'h0000, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_DONE, rtc_pkg::MODE_LISTEN, -512, 0);
        // one quarter dB under the threshold, then exactly on it
        row(rtc_pkg::REQ_CS, 16'h00AA, -361, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_WRONG, rtc_pkg::MODE_LISTEN, -512, 0);
        row(rtc_pkg::REQ_CS, 16'h00AA, -360, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_DONE, rtc_pkg::MODE_RECEIVING, -360, 0);
        row(rtc_pkg::REQ_CS, 16'h0001, -360, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_IGNORED, rtc_pkg::MODE_RECEIVING, -360, 0);
        // mismatched channel, symbol period, modulation
        row(rtc_pkg::REQ_CS, 16'h0002, 0, 5'd26, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_WRONG, rtc_pkg::MODE_RECEIVING, -360, 0);
        row(rtc_pkg::REQ_CS, 16'h0002, 0, 5'd0, 16'h0000, 4'd0, 1, 0);
        row(rtc_pkg::REQ_CS, 16'h0002, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd15, 1, 0);
        // stronger head takes over the capture
        row(rtc_pkg::REQ_CS, 16'h0055, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_DONE, rtc_pkg::MODE_RECEIVING, 0, 0);
        row(rtc_pkg::REQ_RX_END, 16'h00AA, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_WRONG, rtc_pkg::MODE_RECEIVING, 0, 0);
        row(rtc_pkg::REQ_RX_END, 16'h0055, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        typed_as(rtc_pkg::ST_DELIVERED, rtc_pkg::MODE_IDLE, -512, 1);
        // spoiled reception: mode change while holding a frame
        row(rtc_pkg::REQ_LISTEN, 16'h0000, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        row(rtc_pkg::REQ_CS, 16'h0777, -100, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        row(rtc_pkg::REQ_LISTEN, 16'h0000, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        row(rtc_pkg::REQ_CS, 16'h0777, -50, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        row(rtc_pkg::REQ_RX_END, 16'h0777, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        // error drop, then dead node at rx end
        row(rtc_pkg::REQ_CS, 16'h0100, -200, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        row(rtc_pkg::REQ_RX_END, 16'h0100, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 1);
        row(rtc_pkg::REQ_CS, 16'h0101, -200, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 1, 0);
        row(rtc_pkg::REQ_RX_END, 16'h0101, 0, 5'd0, rtc_pkg::SYMBOL_RST, 4'd0, 0, 0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
            send_event(script[i].ev, script[i].typed, script[i].res);

        // Random phases, each under its own register settings
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            settle(SETTLE_CYCLES);
            case (ph)
                0:       apply_settings(5'd26, -512, 16'd1, 4'd15);
                1:       apply_settings(5'd0, -340, 16'hFFFF, 4'd0);
                // sensitivity above the ceiling, used clamped
                2:       apply_settings(5'd13, 0, rtc_pkg::SYMBOL_RST, 4'd5);
                default: apply_settings(5'($urandom_range(0, 26)),
                                        -int'($urandom_range(340, 512)),
                                        16'($urandom_range(1, 65535)),
                                        4'($urandom_range(0, 15)));
            endcase
            if (ph == 1)
            begin
                // long receiver hold while events keep coming back to back
                hold_go     = 1'b1;
                steady_left = 150;
            end
            n = 0;
            while (n < PHASE_EVENTS)
            begin
                draw_event(ev);
                send_event(ev, 1'b0, '0);
                if (ev.req <= rtc_pkg::REQ_IDLE)
                    n++;
            end
        end

        settle(12);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
